// ===== design/ptf_pkg.sv =====
package ptf_pkg;

   localparam int HISTORY_DEPTH = 6;
   localparam int PRESS_WIDTH = 14;
   localparam int TABLE_SIZE = 13;
   localparam int INDEX_WIDTH = $clog2(TABLE_SIZE);

   typedef logic [PRESS_WIDTH-1:0] press_type;
   typedef logic [4:0] letter_type;
   typedef logic [1:0] trend_type;
   typedef logic [1:0] status_type;
   typedef logic [7:0] threshold_type;
   typedef logic [INDEX_WIDTH-1:0] index_type;

   typedef press_type press_table_type [TABLE_SIZE];
   typedef letter_type letter_table_type [TABLE_SIZE];

   localparam trend_type TREND_UNKNOWN = 2'd0;
   localparam trend_type TREND_RISING = 2'd1;
   localparam trend_type TREND_FALLING = 2'd2;
   localparam trend_type TREND_STEADY = 2'd3;

   localparam status_type STATUS_NONE = 2'd0;
   localparam status_type STATUS_OFF_TABLE = 2'd1;
   localparam status_type STATUS_VALID = 2'd2;

   localparam threshold_type THRESHOLD_RESET = 8'd16;

   // Tables run from high to low pressure; unused tail entries are zero.
   localparam index_type RISE_COUNT = INDEX_WIDTH'(13);
   localparam press_table_type RISE_PRESS = '{
      14'd10300, 14'd10220, 14'd10120, 14'd10070, 14'd10000, 14'd9950, 14'd9900,
      14'd9840, 14'd9780, 14'd9700, 14'd9650, 14'd9590, 14'd9470};
   localparam letter_table_type RISE_LETTERS = '{
      5'd0, 5'd1, 5'd2, 5'd5, 5'd6, 5'd8, 5'd9, 5'd11, 5'd12, 5'd16, 5'd19, 5'd24, 5'd25};

   localparam index_type FALL_COUNT = INDEX_WIDTH'(9);
   localparam press_table_type FALL_PRESS = '{
      14'd10500, 14'd10400, 14'd10240, 14'd10180, 14'd10100, 14'd10040, 14'd9980,
      14'd9910, 14'd9850, 14'd0, 14'd0, 14'd0, 14'd0};
   localparam letter_table_type FALL_LETTERS = '{
      5'd0, 5'd1, 5'd3, 5'd7, 5'd14, 5'd17, 5'd20, 5'd21, 5'd23, 5'd0, 5'd0, 5'd0, 5'd0};

   localparam index_type STEADY_COUNT = INDEX_WIDTH'(10);
   localparam press_table_type STEADY_PRESS = '{
      14'd10330, 14'd10230, 14'd10140, 14'd10080, 14'd10000, 14'd9940, 14'd9890,
      14'd9810, 14'd9740, 14'd9600, 14'd0, 14'd0, 14'd0};
   localparam letter_table_type STEADY_LETTERS = '{
      5'd0, 5'd1, 5'd4, 5'd10, 5'd13, 5'd15, 5'd18, 5'd22, 5'd23, 5'd25, 5'd0, 5'd0, 5'd0};

endpackage

// ===== design/ptf_nearest.sv =====
module ptf_nearest (
   input  ptf_pkg::press_type  sample,
   input  ptf_pkg::trend_type  trend,
   output logic                on_table,
   output ptf_pkg::letter_type letter
);
   import ptf_pkg::*;

   press_table_type  press_tab;
   letter_table_type letter_tab;
   index_type        count;
   index_type        best;
   logic [PRESS_WIDTH:0] twice_sample;
   logic [PRESS_WIDTH:0] mid_sum;

   always_comb begin
      case (trend)
         TREND_RISING: begin
            press_tab = RISE_PRESS;
            letter_tab = RISE_LETTERS;
            count = RISE_COUNT;
         end
         TREND_FALLING: begin
            press_tab = FALL_PRESS;
            letter_tab = FALL_LETTERS;
            count = FALL_COUNT;
         end
         default: begin
            press_tab = STEADY_PRESS;
            letter_tab = STEADY_LETTERS;
            count = STEADY_COUNT;
         end
      endcase
   end

   // Table is strictly descending, so the nearest entry is the number of
   // neighbor midpoints lying above the sample. A sample exactly on a
   // midpoint keeps the earlier entry.
   always_comb begin
      twice_sample = {sample, 1'b0};
      best = '0;
      mid_sum = '0;
      for (int i = 1; i < TABLE_SIZE; i++) begin
         mid_sum = {1'b0, press_tab[i-1]} + {1'b0, press_tab[i]};
         if ((INDEX_WIDTH'(i) < count) && (twice_sample < mid_sum)) begin
            best = best + INDEX_WIDTH'(1);
         end
      end
   end

   assign on_table = (sample <= press_tab[0]) && (sample >= press_tab[count - INDEX_WIDTH'(1)]);
   assign letter = on_table ? letter_tab[best] : '0;

endmodule

// ===== design/pressure_trend_forecaster_top.sv =====
// Pressure trend forecaster. Each req transaction carries one sea-level pressure
// sample in dPa (0 means no reading) and yields exactly one rsp transaction with
// the trend code, forecast status, forecast letter and the oldest history sample,
// which the sample is compared against after being shifted into a six-deep history.
// The block takes one transaction per clock cycle while req_stall is low. Each
// accepted sample is held in the input register, passes the trend compare and the
// table nearest-match logic, and its result is held in the result register and
// offered on rsp. req_stall rises only while both
// registers are full and rsp_stall is high. csr_write_data sets the rising/falling
// threshold (reset 16) and should be written while no transaction is in flight.
module pressure_trend_forecaster_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ptf_pkg::press_type      req_pressure_sample,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output ptf_pkg::trend_type      rsp_trend_code,
   output ptf_pkg::status_type     rsp_forecast_status,
   output ptf_pkg::letter_type     rsp_forecast_letter,
   output ptf_pkg::press_type      rsp_oldest_pressure,
   input  logic                    csr_write_enable,
   input  ptf_pkg::threshold_type  csr_write_data
);
   import ptf_pkg::*;

   threshold_type threshold_ff;
   press_type     history_ff [HISTORY_DEPTH];
   trend_type     last_trend_ff;

   logic      stage_valid_ff;
   press_type sample_ff;
   press_type oldest_ff;

   logic       rsp_valid_ff;
   trend_type  rsp_trend_ff;
   status_type rsp_status_ff;
   letter_type rsp_letter_ff;
   press_type  rsp_oldest_ff;

   logic       out_free;
   logic       accept;
   logic       stage_move;
   trend_type  new_trend;
   trend_type  trend_in;
   status_type status_in;
   letter_type letter_in;
   logic       on_table;
   letter_type table_letter;
   logic [PRESS_WIDTH:0] oldest_plus_th;
   logic [PRESS_WIDTH:0] sample_plus_th;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = stage_valid_ff && !out_free;
   assign accept = req_valid && !req_stall;
   assign stage_move = stage_valid_ff && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_write_enable) begin
         threshold_ff <= csr_write_data;
      end
   end

   // Shift on accept; the entry that becomes oldest is captured alongside the sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            history_ff[i] <= '0;
         end
      end else if (accept) begin
         for (int i = 1; i < HISTORY_DEPTH; i++) begin
            history_ff[i-1] <= history_ff[i];
         end
         history_ff[HISTORY_DEPTH-1] <= req_pressure_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         stage_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_pressure_sample;
         oldest_ff <= history_ff[1];
      end
   end

   assign oldest_plus_th = {1'b0, oldest_ff} + {{(PRESS_WIDTH-7){1'b0}}, threshold_ff};
   assign sample_plus_th = {1'b0, sample_ff} + {{(PRESS_WIDTH-7){1'b0}}, threshold_ff};

   always_comb begin
      if ({1'b0, sample_ff} >= oldest_plus_th) begin
         new_trend = TREND_RISING;
      end else if (sample_plus_th <= {1'b0, oldest_ff}) begin
         new_trend = TREND_FALLING;
      end else begin
         new_trend = TREND_STEADY;
      end
   end

   ptf_nearest u_nearest (
      .sample   (sample_ff),
      .trend    (new_trend),
      .on_table (on_table),
      .letter   (table_letter)
   );

   always_comb begin
      if (oldest_ff == '0) begin
         trend_in = last_trend_ff;
         status_in = STATUS_NONE;
         letter_in = '0;
      end else begin
         trend_in = new_trend;
         status_in = on_table ? STATUS_VALID : STATUS_OFF_TABLE;
         letter_in = table_letter;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_trend_ff <= TREND_UNKNOWN;
      end else if (stage_move) begin
         last_trend_ff <= trend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_move) begin
         rsp_trend_ff <= trend_in;
         rsp_status_ff <= status_in;
         rsp_letter_ff <= letter_in;
         rsp_oldest_ff <= oldest_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_trend_code = rsp_trend_ff;
   assign rsp_forecast_status = rsp_status_ff;
   assign rsp_forecast_letter = rsp_letter_ff;
   assign rsp_oldest_pressure = rsp_oldest_ff;

endmodule

// ===== dv/pressure_trend_forecaster_top_tb.sv =====
module pressure_trend_forecaster_top_tb;
   import ptf_pkg::*;

   typedef struct packed {
      trend_type  trend;
      status_type status;
      letter_type letter;
      press_type  oldest;
   } forecast_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   press_type     req_pressure_sample = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   trend_type     rsp_trend_code;
   status_type    rsp_forecast_status;
   letter_type    rsp_forecast_letter;
   press_type     rsp_oldest_pressure;
   logic          csr_write_enable = 1'b0;
   threshold_type csr_write_data = '0;

   pressure_trend_forecaster_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_pressure_sample (req_pressure_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_trend_code      (rsp_trend_code),
      .rsp_forecast_status (rsp_forecast_status),
      .rsp_forecast_letter (rsp_forecast_letter),
      .rsp_oldest_pressure (rsp_oldest_pressure),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   always #5 clock = ~clock;

   // forecast tables, high to low pressure, padded to 13 entries
   int rise_press [13] = '{10300, 10220, 10120, 10070, 10000, 9950, 9900,
                           9840, 9780, 9700, 9650, 9590, 9470};
   int rise_letter [13] = '{0, 1, 2, 5, 6, 8, 9, 11, 12, 16, 19, 24, 25};
   int fall_press [13] = '{10500, 10400, 10240, 10180, 10100, 10040, 9980,
                           9910, 9850, 0, 0, 0, 0};
   int fall_letter [13] = '{0, 1, 3, 7, 14, 17, 20, 21, 23, 0, 0, 0, 0};
   int steady_press [13] = '{10330, 10230, 10140, 10080, 10000, 9940, 9890,
                             9810, 9740, 9600, 0, 0, 0};
   int steady_letter [13] = '{0, 1, 4, 10, 13, 15, 18, 22, 23, 25, 0, 0, 0};

   // predicted block state
   press_type     hist_press [HISTORY_DEPTH] = '{default: '0};
   trend_type     trend_prev = TREND_UNKNOWN;
   threshold_type trend_threshold = THRESHOLD_RESET;

   press_type sample_q [$];
   forecast_type forecast_q [$];

   bit req_fire = 1'b0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   int walk_press = 10100;
   int error_count = 0;
   int samples_taken = 0;
   int settings_run = 1;
   int valid_seen = 0;
   int off_table_seen = 0;
   int no_history_seen = 0;

   function automatic forecast_type predict_forecast(press_type sample);
      forecast_type f;
      int p, diff, th, cnt, best, best_diff, d;
      int tp [13];
      int tl [13];
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) hist_press[i] = hist_press[i+1];
      hist_press[HISTORY_DEPTH-1] = sample;
      f = '0;
      f.oldest = hist_press[0];
      if (hist_press[0] != 0) begin
         p = sample;
         diff = p - int'(hist_press[0]);
         th = trend_threshold;
         // rising is tested first, so a zero threshold makes no change count as rising
         if (diff >= th) begin
            trend_prev = TREND_RISING;
            tp = rise_press;
            tl = rise_letter;
            cnt = 13;
         end else if (diff <= -th) begin
            trend_prev = TREND_FALLING;
            tp = fall_press;
            tl = fall_letter;
            cnt = 9;
         end else begin
            trend_prev = TREND_STEADY;
            tp = steady_press;
            tl = steady_letter;
            cnt = 10;
         end
         if (p > tp[0] || p < tp[cnt-1]) begin
            f.status = STATUS_OFF_TABLE;
         end else begin
            best = 0;
            best_diff = (p > tp[0]) ? p - tp[0] : tp[0] - p;
            for (int i = 1; i < cnt; i++) begin
               d = (p > tp[i]) ? p - tp[i] : tp[i] - p;
               // strict compare: earlier entry keeps a tie
               if (d < best_diff) begin
                  best_diff = d;
                  best = i;
               end
            end
            f.status = STATUS_VALID;
            f.letter = letter_type'(tl[best]);
         end
      end
      f.trend = trend_prev;
      return f;
   endfunction

   // mostly a slow pressure walk, with table hits, ties, repeats and noise
   function automatic press_type weather_sample();
      int r, t, i, cnt, v;
      int tp [13];
      r = $urandom_range(99);
      if (r < 6) begin
         v = 0;
      end else if (r < 14) begin
         v = $urandom_range(16383);
      end else if (r < 26) begin
         v = walk_press;
      end else if (r < 40) begin
         t = $urandom_range(2);
         case (t)
            0: begin tp = rise_press; cnt = 13; end
            1: begin tp = fall_press; cnt = 9; end
            default: begin tp = steady_press; cnt = 10; end
         endcase
         i = $urandom_range(cnt - 1);
         case ($urandom_range(3))
            0: v = tp[i];
            1: v = tp[i] + 1;
            2: v = tp[i] - 1;
            default: v = (i < cnt - 1) ? (tp[i] + tp[i+1]) / 2 : tp[i];
         endcase
         walk_press = v;
      end else begin
         walk_press = walk_press + int'($urandom_range(160)) - 80;
         if (walk_press < 9300) walk_press = 9300;
         if (walk_press > 10700) walk_press = 10700;
         v = walk_press;
      end
      return press_type'(v);
   endfunction

   task automatic flag_mismatch(input string what);
      if (error_count < 40) $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // checked at the rising edge, where the queues and req_valid are settled
   task automatic drain();
      do @(posedge clock);
      while (sample_q.size() != 0 || req_valid || forecast_q.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic run_phase(input bit do_write, input int thr_val, input int n_rand,
                            input int s_pct, input int r_pct, input int hold_cycles);
      drain();
      if (do_write) begin
         @(negedge clock);
         csr_write_enable <= 1'b1;
         csr_write_data <= threshold_type'(thr_val);
         @(negedge clock);
         csr_write_enable <= 1'b0;
         settings_run++;
      end
      @(posedge clock);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (n_rand) sample_q.push_back(weather_sample());
      hold_left = hold_cycles;
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_pressure_sample <= sample_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_left != 0) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(negedge clock) begin
      if (hold_left != 0) hold_left <= hold_left - 1;
   end

   // monitor and checker
   always @(posedge clock) begin
      forecast_type exp_f;
      req_fire = 1'b0;
      if (!reset) begin
         if (csr_write_enable) trend_threshold = csr_write_data;
         if (req_valid && !req_stall) begin
            req_fire = 1'b1;
            forecast_q.push_back(predict_forecast(req_pressure_sample));
            samples_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (forecast_q.size() == 0) begin
               flag_mismatch("response transaction with no sample outstanding");
            end else begin
               exp_f = forecast_q.pop_front();
               if (rsp_trend_code !== exp_f.trend ||
                   rsp_forecast_status !== exp_f.status ||
                   rsp_forecast_letter !== exp_f.letter ||
                   rsp_oldest_pressure !== exp_f.oldest)
                  flag_mismatch($sformatf(
                     "trend %0d/%0d status %0d/%0d letter %0d/%0d oldest %0d/%0d (got/exp)",
                     rsp_trend_code, exp_f.trend, rsp_forecast_status, exp_f.status,
                     rsp_forecast_letter, exp_f.letter, rsp_oldest_pressure, exp_f.oldest));
               case (exp_f.status)
                  STATUS_VALID: valid_seen++;
                  STATUS_OFF_TABLE: off_table_seen++;
                  default: no_history_seen++;
               endcase
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("pressure_trend_forecaster_top regression: fail");
      $finish;
   end

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed: empty history, steady tie, table edges, zero samples
      @(posedge clock);
      send_idle_pct = 21;
      recv_idle_pct = 51;
      repeat (6) sample_q.push_back(press_type'(10280));
      sample_q.push_back(press_type'(16383));
      sample_q.push_back(press_type'(0));
      sample_q.push_back(press_type'(10300));
      sample_q.push_back(press_type'(10301));
      sample_q.push_back(press_type'(9470));
      sample_q.push_back(press_type'(9469));
      sample_q.push_back(press_type'(1));
      sample_q.push_back(press_type'(10500));
      sample_q.push_back(press_type'(9850));
      sample_q.push_back(press_type'(10330));
      sample_q.push_back(press_type'(9600));
      repeat (6) sample_q.push_back(press_type'(0));
      sample_q.push_back(press_type'(10000));

      // zero threshold: flat runs count as rising
      run_phase(1'b1, 0, 0, 21, 51, 0);
      repeat (7) sample_q.push_back(press_type'(10000));
      repeat (150) sample_q.push_back(weather_sample());

      run_phase(1'b1, 255, 200, 51, 21, 0);
      run_phase(1'b1, $urandom_range(255), 200, 51, 21, 0);
      // long receiver hold-off while the sender keeps offering
      run_phase(1'b1, 16, 250, 0, 0, 300);
      run_phase(1'b1, 1, 225, 0, 0, 0);

      drain();
      repeat (10) @(negedge clock);
      $display("ran %0d samples over %0d threshold settings", samples_taken, settings_run);
      $display("forecasts: %0d valid, %0d off table, %0d without history",
               valid_seen, off_table_seen, no_history_seen);
      if (error_count == 0) begin
         $display("pressure_trend_forecaster_top regression: pass");
      end else begin
         $display("pressure_trend_forecaster_top regression: fail");
      end
      $finish;
   end

endmodule

// ===== pressure_trend_forecaster_top.f =====
design/ptf_pkg.sv
design/ptf_nearest.sv
design/pressure_trend_forecaster_top.sv
dv/pressure_trend_forecaster_top_tb.sv
